@@ hw/rtl/tun_pkg.sv @@
// tun_pkg: shared constants and types for the triangle unit normal block.
// No dependencies; used by the interfaces and imported by every module.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  // normalized magnitude width fed to the square / root / divide datapath
  localparam int MAG_BITS         = 31;

  // sideband that rides along the root and divide stages
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tun_side_t;
endpackage

@@ hw/rtl/tun_in_if.sv @@
// tun_in_if / tun_out_if: valid/ready channels of the triangle unit normal block.
// Depends on tun_pkg for default widths.
`timescale 1ns / 1ps
interface tun_in_if #(parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
  modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 input ready);
  modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               output ready);
endinterface

interface tun_out_if #(parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS);
  logic                                 valid;
  logic                                 ready;
  logic signed [NORMAL_FRAC_BITS+1:0]   normal_x, normal_y, normal_z;
  logic                                 degenerate;
  modport source(output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink(input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

@@ hw/rtl/tun_sqrt_div.sv @@
// tun_sqrt_div: pipelined integer square root of the magnitude sum, then three
// pipelined restoring dividers that scale and round each component. Uses tun_pkg.
`timescale 1ns / 1ps
module tun_sqrt_div #(
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2*tun_pkg::MAG_BITS+1:0]         in_sum,
  input  logic [2:0][tun_pkg::MAG_BITS-1:0]      in_mag,
  input  tun_pkg::tun_side_t                     in_side,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0][NORMAL_FRAC_BITS+1:0]       out_nrm,
  output logic                                   out_degen
);
  import tun_pkg::*;

  localparam int F    = NORMAL_FRAC_BITS;
  localparam int SW   = 2*MAG_BITS + 2;      // sum width
  localparam int RW   = MAG_BITS + 1;        // root width = root steps
  localparam int NUMW = MAG_BITS + F + 1;    // scaled numerator width
  localparam int QW   = F + 1;               // quotient width
  localparam int NRMW = F + 2;
  localparam int DS   = RW + QW + 2;         // root, pre, divide, output

  logic [DS-1:0] v_r;
  logic [DS:0]   en;

  always_comb begin
    en[DS] = out_ready;
    for (int i = DS-1; i >= 0; i--) en[i] = !v_r[i] | en[i+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < DS; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? in_valid : v_r[i-1];
      end
    end
  end

  // root stages: index 0 is the module input
  logic [SW-1:0]                s_r  [0:RW];
  logic [SW-1:0]                rt_r [0:RW];
  logic [2:0][MAG_BITS-1:0]     m_r  [0:RW];
  tun_side_t                    sd_r [0:RW];

  assign s_r[0]  = in_sum;
  assign rt_r[0] = '0;
  assign m_r[0]  = in_mag;
  assign sd_r[0] = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_root
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
    logic [SW-1:0] trial;
    logic [SW-1:0] s_nxt, rt_nxt;
    always_comb begin
      trial = rt_r[k] + BIT;
      if (s_r[k] >= trial) begin
        s_nxt  = s_r[k] - trial;
        rt_nxt = (rt_r[k] >> 1) + BIT;
      end else begin
        s_nxt  = s_r[k];
        rt_nxt = rt_r[k] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        s_r[k+1]  <= s_nxt;
        rt_r[k+1] <= rt_nxt;
        m_r[k+1]  <= m_r[k];
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  // divide stages: index 0 is the pre stage output
  logic [RW-1:0]            r_r   [0:QW];
  logic [2:0][NUMW-1:0]     num_r [0:QW];
  logic [2:0][RW-1:0]       rem_r [0:QW];
  logic [2:0][QW-1:0]       q_r   [0:QW];
  tun_side_t                dsd_r [0:QW];

  // pre stage: numerator = m * 2^F + floor(r/2), remainder seeded with top bits
  always_ff @(posedge clk) begin
    if (en[RW]) begin
      r_r[0]   <= rt_r[RW][RW-1:0];
      dsd_r[0] <= sd_r[RW];
      for (int c = 0; c < 3; c++) begin
        logic [NUMW-1:0] num;
        num = {1'b0, m_r[RW][c], F'(0)} + NUMW'(rt_r[RW][RW-1:1]);
        num_r[0][c] <= num;
        rem_r[0][c] <= RW'(num[NUMW-1:QW]);
        q_r[0][c]   <= '0;
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    always_ff @(posedge clk) begin
      if (en[RW+1+j]) begin
        r_r[j+1]   <= r_r[j];
        num_r[j+1] <= num_r[j];
        dsd_r[j+1] <= dsd_r[j];
        for (int c = 0; c < 3; c++) begin
          logic [RW:0] trial;
          trial = {rem_r[j][c], num_r[j][c][B]};
          if (trial >= {1'b0, r_r[j]}) begin
            rem_r[j+1][c] <= RW'(trial - {1'b0, r_r[j]});
            q_r[j+1][c]   <= {q_r[j][c][QW-2:0], 1'b1};
          end else begin
            rem_r[j+1][c] <= trial[RW-1:0];
            q_r[j+1][c]   <= {q_r[j][c][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output register: apply sign, force zero on a degenerate triangle
  logic [2:0][NRMW-1:0] nrm_r;
  logic                 dg_r;
  always_ff @(posedge clk) begin
    if (en[DS-1]) begin
      dg_r <= dsd_r[QW].degen;
      for (int c = 0; c < 3; c++) begin
        if (dsd_r[QW].degen)
          nrm_r[c] <= '0;
        else if (dsd_r[QW].neg[c])
          nrm_r[c] <= NRMW'(0) - {1'b0, q_r[QW][c]};
        else
          nrm_r[c] <= {1'b0, q_r[QW][c]};
      end
    end
  end

  assign out_valid = v_r[DS-1];
  assign out_nrm   = nrm_r;
  assign out_degen = dg_r;
endmodule

@@ hw/rtl/triangle_unit_normal_top.sv @@
// triangle_unit_normal_top: unit face normal of a triangle, fully pipelined.
// Depends on tun_pkg, tun_in_if / tun_out_if and tun_sqrt_div.
`timescale 1ns / 1ps
// Usage:
//   in_ch  (sink)  : one triangle per item, vertices A, B, C as signed
//                    Q8.8 coordinates (COORD_WIDTH bits each).
//   out_ch (source): one result per item, normal_x/y/z in signed
//                    Q1.NORMAL_FRAC_BITS rounded to nearest, plus degenerate,
//                    which is set (with a zero vector) when the cross product
//                    is exactly zero.
//   No configuration, no state between items.
// Throughput: one item per cycle, sustained while out_ch.ready is high.
// Stages: 5 + clog2(max(2*COORD_WIDTH+3, 31)) front stages (edges, products,
//   cross/abs, one stage per normalize shift level, squares, sum), then
//   32 root stages (one result bit each), one numerator stage,
//   NORMAL_FRAC_BITS+1 divide stages (one quotient bit each) and an output
//   register.
// Stall: each full stage holds while its successor holds, so bubbles close up
//   and in_ch.ready stays high until every stage holds an item.
// Reset: rst_n synchronous, active low, clears all stage valid bits; the
//   pipeline comes out of reset empty and ready.
module triangle_unit_normal_top #(
  parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  tun_in_if.sink    in_ch,
  tun_out_if.source out_ch
);
  import tun_pkg::*;

  localparam int EW  = COORD_WIDTH + 1;          // edge width
  localparam int PW  = 2*EW;                     // product width
  localparam int XW  = PW + 1;                   // cross component width
  localparam int NW  = (XW > MAG_BITS) ? XW : MAG_BITS;  // normalize word
  localparam int NS  = $clog2(NW);               // normalize levels
  localparam int TS  = NS + 5;                   // front stages
  localparam int SW  = 2*MAG_BITS + 2;
  localparam int NRMW = NORMAL_FRAC_BITS + 2;

  logic [TS-1:0] v_r;
  logic [TS:0]   en;
  logic          sd_ready;

  always_comb begin
    en[TS] = sd_ready;
    for (int i = TS-1; i >= 0; i--) en[i] = !v_r[i] | en[i+1];
  end
  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < TS; i++) begin
        if (en[i]) v_r[i] <= (i == 0) ? in_ch.valid : v_r[i-1];
      end
    end
  end

  // stage 0: edges E1 = B - A, E2 = C - B
  logic signed [2:0][EW-1:0] e1_r, e2_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1_r[0] <= EW'($signed(in_ch.b_x) - $signed(in_ch.a_x));
      e1_r[1] <= EW'($signed(in_ch.b_y) - $signed(in_ch.a_y));
      e1_r[2] <= EW'($signed(in_ch.b_z) - $signed(in_ch.a_z));
      e2_r[0] <= EW'($signed(in_ch.c_x) - $signed(in_ch.b_x));
      e2_r[1] <= EW'($signed(in_ch.c_y) - $signed(in_ch.b_y));
      e2_r[2] <= EW'($signed(in_ch.c_z) - $signed(in_ch.b_z));
    end
  end

  // stage 1: six signed products; pl[i]/pr[i] are the two terms of cross[i]
  logic signed [PW-1:0] pl_r [3];
  logic signed [PW-1:0] pr_r [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pl_r[0] <= $signed(e1_r[1]) * $signed(e2_r[2]);
      pr_r[0] <= $signed(e1_r[2]) * $signed(e2_r[1]);
      pl_r[1] <= $signed(e1_r[2]) * $signed(e2_r[0]);
      pr_r[1] <= $signed(e1_r[0]) * $signed(e2_r[2]);
      pl_r[2] <= $signed(e1_r[0]) * $signed(e2_r[1]);
      pr_r[2] <= $signed(e1_r[1]) * $signed(e2_r[0]);
    end
  end

  // stage 2: cross components, split into sign and magnitude
  logic [NW-1:0] nm_r  [0:NS][3];
  logic [2:0]    neg_r [0:NS];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [XW-1:0] x;
        x = XW'(pl_r[c]) - XW'(pr_r[c]);
        neg_r[0][c] <= x[XW-1];
        nm_r[0][c]  <= NW'(x[XW-1] ? XW'(-x) : XW'(x));
      end
    end
  end

  // normalize: shift all three left together until the largest has its MSB set
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - k);
    logic [NW-1:0] orw;
    assign orw = nm_r[k][0] | nm_r[k][1] | nm_r[k][2];
    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        neg_r[k+1] <= neg_r[k];
        for (int c = 0; c < 3; c++) begin
          if (orw[NW-1 -: SH] == '0) nm_r[k+1][c] <= nm_r[k][c] << SH;
          else                       nm_r[k+1][c] <= nm_r[k][c];
        end
      end
    end
  end

  // squares of the top MAG_BITS bits; all zero only on a degenerate triangle
  logic [2:0][MAG_BITS-1:0]   mq_r;
  logic [2*MAG_BITS-1:0]      sq_r [3];
  tun_side_t                  sq_sd_r;
  always_ff @(posedge clk) begin
    if (en[3+NS]) begin
      for (int c = 0; c < 3; c++) begin
        mq_r[c] <= nm_r[NS][c][NW-1 -: MAG_BITS];
        sq_r[c] <= nm_r[NS][c][NW-1 -: MAG_BITS] * nm_r[NS][c][NW-1 -: MAG_BITS];
      end
      sq_sd_r.neg   <= neg_r[NS];
      sq_sd_r.degen <= (nm_r[NS][0] | nm_r[NS][1] | nm_r[NS][2]) == '0;
    end
  end

  // sum of squares
  logic [SW-1:0]            sum_r;
  logic [2:0][MAG_BITS-1:0] sm_r;
  tun_side_t                sm_sd_r;
  always_ff @(posedge clk) begin
    if (en[4+NS]) begin
      sum_r   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      sm_r    <= mq_r;
      sm_sd_r <= sq_sd_r;
    end
  end

  logic [2:0][NRMW-1:0] nrm;

  tun_sqrt_div #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_sqrt_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[TS-1]),
    .in_ready  (sd_ready),
    .in_sum    (sum_r),
    .in_mag    (sm_r),
    .in_side   (sm_sd_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_nrm   (nrm),
    .out_degen (out_ch.degenerate)
  );

  assign out_ch.normal_x = nrm[0];
  assign out_ch.normal_y = nrm[1];
  assign out_ch.normal_z = nrm[2];
endmodule
